[design/min_distance_point_acceptor_macros.svh]
// Assertion macros for the minimum-distance point acceptor.
// Expects signals clk and rst in the scope of use.
`ifndef MIN_DISTANCE_POINT_ACCEPTOR_MACROS_SVH
`define MIN_DISTANCE_POINT_ACCEPTOR_MACROS_SVH

// same-cycle implication
`define MDPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mdpa_pkg.sv]
// Shared types and constants for the minimum-distance point acceptor.
// No dependencies.
`default_nettype none

package mdpa_pkg;

  localparam int COORD_W        = 12;
  localparam int POINT_W        = 2 * COORD_W;
  localparam int SQ_W           = 2 * COORD_W;
  localparam int SUM_W          = SQ_W + 1;
  localparam int TARGET_W       = 8;
  localparam int VERDICT_W      = 2;
  localparam int SLOT_W         = 7;
  localparam int COUNT_OUT_W    = 8;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 24;
  localparam int OUT_FIELDS_W   = VERDICT_W + SLOT_W + COUNT_OUT_W + 1;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;
  localparam int MAX_POINTS_DEF = 128;

  localparam logic [CFG_IDX_W-1:0] REG_EXCL_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXCL_RAD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd5;

  localparam logic [COORD_W-1:0]  RST_CENTER_X  = 12'd640;
  localparam logic [COORD_W-1:0]  RST_CENTER_Y  = 12'd400;
  localparam logic [COORD_W-1:0]  RST_EXCL_RAD  = 12'd105;
  localparam logic [COORD_W-1:0]  RST_MIN_SPACE = 12'd40;
  localparam logic [TARGET_W-1:0] RST_TARGET    = 8'd100;

  typedef enum logic [VERDICT_W-1:0] {
    V_ACCEPT   = 2'd0,
    V_EXCLUDED = 2'd1,
    V_CLOSE    = 2'd2,
    V_FULL     = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EXCL_CMP,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/mdpa_cell.sv]
// One storage cell of the point ring: holds a stored point, loads a new one
// or takes its neighbour's. Depends on mdpa_pkg.
`default_nettype none

module mdpa_cell
  import mdpa_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [POINT_W-1:0] shift_in,
  input  wire logic [POINT_W-1:0] load_data,
  output logic      [POINT_W-1:0] point
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      point <= load_data;
    end else if (ctrl.shift) begin
      point <= shift_in;
    end
  end

endmodule

`default_nettype wire

[design/mdpa_dist.sv]
// Squared distance unit: registered squares of |dx| and |dy|, sum out.
// Depends on mdpa_pkg.
`default_nettype none

module mdpa_dist
  import mdpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [COORD_W-1:0] ax,
  input  wire logic [COORD_W-1:0] ay,
  input  wire logic [COORD_W-1:0] bx,
  input  wire logic [COORD_W-1:0] by,
  output logic      [SUM_W-1:0]   dsq
);

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;

  assign dx = (ax > bx) ? (ax - bx) : (bx - ax);
  assign dy = (ay > by) ? (ay - by) : (by - ay);

  always_ff @(posedge clk) begin
    sq_x <= SQ_W'(dx) * SQ_W'(dx);
    sq_y <= SQ_W'(dy) * SQ_W'(dy);
  end

  assign dsq = {1'b0, sq_x} + {1'b0, sq_y};

endmodule

`default_nettype wire

[design/min_distance_point_acceptor.sv]
// Minimum-distance point acceptor: one candidate point in, one verdict out.
// Points are kept in a ring of MAX_POINTS cells that rotates once past a
// single squared-distance unit for every candidate that gets to the spacing
// test, which passes S_CHECK, S_EXCL_CMP, S_SCAN, S_DRAIN, S_FINISH in turn;
// a full table goes from S_CHECK to S_FINISH, an excluded point from S_EXCL_CMP.
// The next candidate is taken once the block is back in idle, even while the
// previous result still waits at the output. Configuration writes are
// always ready; write them only while no candidate is in flight.
`default_nettype none

`include "min_distance_point_acceptor_macros.svh"

module min_distance_point_acceptor
  import mdpa_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // candidate items
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // cand_x[11:0], cand_y[23:12]
  // result items
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,   // verdict[1:0], slot[8:2],
                                                // stored_count[16:9], full_res[17]
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LIM_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

  // configuration
  logic                excl_en;
  logic [COORD_W-1:0]  center_x;
  logic [COORD_W-1:0]  center_y;
  logic [COORD_W-1:0]  excl_rad;
  logic [COORD_W-1:0]  min_space;
  logic [TARGET_W-1:0] target;
  logic [SQ_W-1:0]     excl_sq;
  logic [SQ_W-1:0]     space_sq;

  // control
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [IDX_W-1:0]   k;
  logic               tag;
  logic               close;
  verdict_t           verdict;
  logic [LIM_W-1:0]   limit;
  logic               full_now;
  logic               hit;
  logic               scan_last;
  logic               out_free;
  logic               out_load;
  logic               shift_en;
  logic               wr_en;
  logic               use_center;

  // candidate and datapath
  logic [COORD_W-1:0] cand_x;
  logic [COORD_W-1:0] cand_y;
  logic [COORD_W-1:0] ref_x;
  logic [COORD_W-1:0] ref_y;
  logic [SUM_W-1:0]   dsq;
  logic [POINT_W-1:0] pts [MAX_POINTS];
  logic [IDX_W-1:0]   wr_idx;

  // result
  logic [VERDICT_W-1:0]   res_verdict;
  logic [SLOT_W-1:0]      res_slot;
  logic [COUNT_OUT_W-1:0] res_count;
  logic                   res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      excl_en   <= 1'b1;
      center_x  <= RST_CENTER_X;
      center_y  <= RST_CENTER_Y;
      excl_rad  <= RST_EXCL_RAD;
      min_space <= RST_MIN_SPACE;
      target    <= RST_TARGET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXCL_EN:   excl_en   <= cfg_data[0];
        REG_CENTER_X:  center_x  <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:  center_y  <= cfg_data[COORD_W-1:0];
        REG_EXCL_RAD:  excl_rad  <= cfg_data[COORD_W-1:0];
        REG_MIN_SPACE: min_space <= cfg_data[COORD_W-1:0];
        REG_TARGET:    target    <= cfg_data[TARGET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    excl_sq  <= SQ_W'(excl_rad) * SQ_W'(excl_rad);
    space_sq <= SQ_W'(min_space) * SQ_W'(min_space);
  end

  // effective limit saturates at table size
  assign limit = (LIM_W'(target) > LIM_W'(MAX_POINTS)) ? LIM_W'(MAX_POINTS)
                                                        : LIM_W'(target);
  assign full_now  = LIM_W'(count) >= limit;
  assign hit       = tag && (dsq < {1'b0, space_sq});
  assign scan_last = k == IDX_W'(MAX_POINTS - 1);
  assign out_free  = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = full_now ? S_FINISH : S_EXCL_CMP;
      end
      S_EXCL_CMP: begin
        if (excl_en && (dsq < {1'b0, excl_sq})) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready   = 1'b0;
    shift_en   = 1'b0;
    use_center = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE:     s_tready   = 1'b1;
      S_CHECK:    use_center = 1'b1;
      S_EXCL_CMP: begin
      end
      S_SCAN:     shift_en   = 1'b1;
      S_DRAIN: begin
      end
      S_FINISH:   out_load   = out_free;
      default: begin
      end
    endcase
  end

  assign wr_en      = out_load && (verdict == V_ACCEPT);
  assign count_next = wr_en ? count + 1'b1 : count;
  assign wr_idx     = count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      k       <= '0;
      tag     <= 1'b0;
      close   <= 1'b0;
      verdict <= V_ACCEPT;
    end else begin
      state <= state_next;
      count <= count_next;
      tag   <= (state == S_SCAN) && (CNT_W'(k) < count);
      unique case (state)
        S_CHECK: begin
          verdict <= full_now ? V_FULL : V_ACCEPT;
        end
        S_EXCL_CMP: begin
          k     <= '0;
          close <= 1'b0;
          if (excl_en && (dsq < {1'b0, excl_sq})) begin
            verdict <= V_EXCLUDED;
          end
        end
        S_SCAN: begin
          k     <= k + 1'b1;
          close <= close | hit;
        end
        S_DRAIN: begin
          verdict <= (close | hit) ? V_CLOSE : V_ACCEPT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cand_x <= s_tdata[COORD_W-1:0];
      cand_y <= s_tdata[2*COORD_W-1:COORD_W];
    end
  end

  // ring of point cells; cell 0 is the head seen by the distance unit
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_POINTS;
    cell_ctrl_t ctrl;
    assign ctrl.shift = shift_en;
    assign ctrl.load  = wr_en && (wr_idx == IDX_W'(i));
    mdpa_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .shift_in  (pts[NXT]),
      .load_data ({cand_y, cand_x}),
      .point     (pts[i])
    );
  end

  assign ref_x = use_center ? center_x : pts[0][COORD_W-1:0];
  assign ref_y = use_center ? center_y : pts[0][POINT_W-1:COORD_W];

  mdpa_dist u_dist (
    .clk (clk),
    .ax  (cand_x),
    .ay  (cand_y),
    .bx  (ref_x),
    .by  (ref_y),
    .dsq (dsq)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_verdict <= verdict;
      res_slot    <= (verdict == V_ACCEPT) ? SLOT_W'(count) : '0;
      res_count   <= COUNT_OUT_W'(count_next);
      res_full    <= LIM_W'(count_next) >= limit;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                    res_full, res_count, res_slot, res_verdict};

  `MDPA_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(MAX_POINTS),
    "point count above table size")
  `MDPA_ASSERT_IMP(a_accept_room, wr_en, !full_now,
    "point stored into a full table")
  `MDPA_ASSERT_NXT(a_count_step, wr_en, count == $past(count) + 1'b1,
    "point count did not advance after a store")

endmodule

`default_nettype wire

[tb/min_distance_point_acceptor_test.sv]
// Testbench for the minimum-distance point acceptor. It streams candidate points
// through the block and checks every verdict against an acceptance model in the bench.
// Depends on mdpa_pkg and min_distance_point_acceptor.
`timescale 1ns / 100ps

module min_distance_point_acceptor_test;
  import mdpa_pkg::*;

  localparam int TABLE_DEPTH   = MAX_POINTS_DEF;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = TABLE_DEPTH + 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_TARGET + 3'd1;

  typedef logic [COORD_W-1:0] coord_t;

  // same layout as the low bits of m_tdata
  typedef struct packed {
    logic                   full;
    logic [COUNT_OUT_W-1:0] stored;
    logic [SLOT_W-1:0]      slot;
    verdict_t               verdict;
  } verdict_item_t;

  class verdict_board;
    bit                  excl_en;
    coord_t              cx, cy, excl_rad, spacing;
    logic [TARGET_W-1:0] target;
    coord_t              px[TABLE_DEPTH];
    coord_t              py[TABLE_DEPTH];
    int unsigned         stored;
    verdict_item_t       pending_verdicts[$];
    int                  errors;

    function new();
      excl_en  = 1'b1;
      cx       = RST_CENTER_X;
      cy       = RST_CENTER_Y;
      excl_rad = RST_EXCL_RAD;
      spacing  = RST_MIN_SPACE;
      target   = RST_TARGET;
      stored   = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_EXCL_EN:   excl_en = data[0];
        REG_CENTER_X:  cx = data;
        REG_CENTER_Y:  cy = data;
        REG_EXCL_RAD:  excl_rad = data;
        REG_MIN_SPACE: spacing = data;
        REG_TARGET:    target = data[TARGET_W-1:0];
        default: ;
      endcase
    endfunction

    static function logic [SUM_W-1:0] dist_sq(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
      coord_t dx, dy;
      dx = (x0 > x1) ? x0 - x1 : x1 - x0;
      dy = (y0 > y1) ? y0 - y1 : y1 - y0;
      return SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
    endfunction

    function int unsigned fill_limit();
      return (target > TABLE_DEPTH) ? TABLE_DEPTH : target;
    endfunction

    // full test first, then exclusion, then spacing against every stored point
    function void take_candidate(coord_t x, coord_t y);
      verdict_item_t    r;
      int unsigned      lim;
      int unsigned      i;
      logic [SQ_W-1:0]  sp2, rad2;
      lim  = fill_limit();
      sp2  = SQ_W'(spacing) * SQ_W'(spacing);
      rad2 = SQ_W'(excl_rad) * SQ_W'(excl_rad);
      r = '0;
      r.verdict = V_ACCEPT;
      if (stored >= lim) begin
        r.verdict = V_FULL;
      end else if (excl_en && dist_sq(x, y, cx, cy) < rad2) begin
        r.verdict = V_EXCLUDED;
      end else begin
        for (i = 0; i < stored; i++) begin
          if (dist_sq(x, y, px[i], py[i]) < sp2) begin
            r.verdict = V_CLOSE;
            break;
          end
        end
        if (r.verdict == V_ACCEPT) begin
          r.slot = SLOT_W'(stored);
          px[stored] = x;
          py[stored] = y;
          stored++;
        end
      end
      r.stored = COUNT_OUT_W'(stored);
      r.full   = (stored >= lim);
      pending_verdicts.insert(pending_verdicts.size(), r);
    endfunction

    function void check_verdict(logic [OUT_DATA_W-1:0] data);
      verdict_item_t got, want;
      got = verdict_item_t'(data[OUT_FIELDS_W-1:0]);
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result item with nothing pending: %h", $time, data);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict || got.slot !== want.slot ||
          got.stored !== want.stored || got.full !== want.full) begin
        errors++;
        if (errors <= 10)
          $display("%0t: verdict exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d (verdict/slot/count/full)",
                   $time, want.verdict, want.slot, want.stored, want.full,
                   got.verdict, got.slot, got.stored, got.full);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  verdict_board sb;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  bit           hold_req;

  min_distance_point_acceptor DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_verdict(m_tdata);
  end

  function automatic coord_t near(coord_t c, int unsigned reach);
    int v;
    v = int'(c) + int'($urandom_range(2 * reach)) - int'(reach);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  // mostly points around stored ones and around the centre, where verdicts are decided
  function automatic void pick_candidate(output coord_t x, output coord_t y);
    int unsigned roll, k;
    roll = $urandom_range(99);
    if (roll < 45 && sb.stored > 0) begin
      k = $urandom_range(sb.stored - 1);
      x = near(sb.px[k], sb.spacing + 4);
      y = near(sb.py[k], sb.spacing + 4);
    end else if (roll < 60) begin
      x = near(sb.cx, sb.excl_rad + 4);
      y = near(sb.cy, sb.excl_rad + 4);
    end else if (roll < 68) begin
      x = $urandom_range(1) ? '1 : '0;
      y = $urandom_range(1) ? '1 : '0;
    end else begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
    end
  endfunction

  task automatic send_point(coord_t x, coord_t y);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    sb.take_candidate(x, y);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(bit en, coord_t cx, coord_t cy, coord_t rad, coord_t sp,
                           logic [TARGET_W-1:0] tgt, int unsigned n);
    coord_t x, y;
    wait_idle();
    // unused upper bits go in random
    write_reg(REG_EXCL_EN, CFG_DATA_W'({$urandom, en}));
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_EXCL_RAD, rad);
    write_reg(REG_MIN_SPACE, sp);
    write_reg(REG_TARGET, CFG_DATA_W'({$urandom, tgt}));
    write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(1)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    repeat (n) begin
      pick_candidate(x, y);
      send_point(x, y);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 86;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: exclusion edge, spacing edge, corners, zero distance
    send_point(640, 400);
    send_point(744, 400);
    send_point(745, 400);
    send_point(784, 400);
    send_point(785, 400);
    send_point(0, 0);
    send_point(4095, 4095);
    send_point(4095, 0);
    send_point(0, 4095);
    send_point(0, 0);
    send_point(640, 505);
    send_point(4095, 4094);

    // full takes precedence over exclusion and spacing
    wait_idle();
    write_reg(REG_TARGET, {4'hF, TARGET_W'(sb.stored)});
    cfg_valid <= 1'b0;
    send_point(2000, 2000);
    send_point(640, 400);
    send_point(0, 0);

    // zero target, then unknown indexes must change nothing
    wait_idle();
    write_reg(REG_TARGET, '0);
    write_reg(REG_SPARE, '1);
    write_reg(REG_SPARE + 3'd1, '1);
    cfg_valid <= 1'b0;
    send_point(1000, 1000);
    send_point(1000, 1000);

    // exclusion off: the centre point becomes eligible and fills the table
    wait_idle();
    write_reg(REG_EXCL_EN, 12'hFFE);
    write_reg(REG_TARGET, CFG_DATA_W'(sb.stored + 1));
    cfg_valid <= 1'b0;
    send_point(640, 400);
    send_point(640, 400);

    wait_idle();
    write_reg(REG_TARGET, CFG_DATA_W'(sb.stored + 1));
    cfg_valid <= 1'b0;
    send_point(640, 400);

    // zero spacing never refuses
    wait_idle();
    write_reg(REG_MIN_SPACE, '0);
    write_reg(REG_TARGET, CFG_DATA_W'(sb.stored + 1));
    cfg_valid <= 1'b0;
    send_point(640, 400);

    run_phase(1'b1, coord_t'($urandom), coord_t'($urandom), 300, 200, 30, 110);
    run_phase(1'b0, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 350, 45, 100);
    run_phase(1'b1, '1, '1, '1, 120, 60, 70);

    tx_idle_pct = 86;
    rx_idle_pct = 20;
    run_phase(1'b1, '0, '0, '0, '1, 70, 50);
    run_phase(bit'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom_range(600)), 150, 90, 100);
    run_phase(1'b1, coord_t'($urandom), coord_t'($urandom), 200,
              coord_t'($urandom_range(40, 90)), 110, 110);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    hold_req = 1'b1;
    run_phase(1'b1, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom_range(400)),
              60, 200, 100);
    run_phase(1'b0, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), '0, 255, 80);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
